>>> sv/sbf_pkg.sv
// shared types and constants for the beacon slot sync and led fader
// no dependencies, compiled first
package sbf_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_PACKET   = 2'd1,
        MODE_SUBCYCLE = 2'd2,
        MODE_TX_SLOT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RADIO_NONE    = 3'd0,
        RADIO_RX      = 3'd1,
        RADIO_IDLE    = 3'd2,
        RADIO_TX_IDLE = 3'd3,
        RADIO_TX_RX   = 3'd4
    } radio_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_ADDR     = 3'd0,
        REG_COMMAND_CODE = 3'd1,
        REG_SUBCYCLES    = 3'd2,
        REG_BAND_LOW_TOP = 3'd3,
        REG_BAND_MID_TOP = 3'd4,
        REG_DELAY_LONG   = 3'd5,
        REG_DELAY_MID    = 3'd6,
        REG_DELAY_FAST   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  own_addr;
        logic [7:0]  command_code;
        logic [7:0]  subcycles;
        logic [7:0]  band_low_top;
        logic [7:0]  band_mid_top;
        logic [15:0] delay_long;
        logic [15:0] delay_mid;
        logic [15:0] delay_fast;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  pkt_command;
        logic [7:0]  pkt_sender;
        logic [7:0]  pkt_cycle;
        logic [15:0] pkt_time;
        logic [15:0] timer_now;
    } req_t;

    typedef struct packed {
        logic [7:0]  led_level;
        logic        led_enable;
        logic [7:0]  cycle_index;
        logic        load_timer;
        logic [15:0] timer_value;
        radio_cmd_t  radio_cmd;
        logic [7:0]  tx_addr;
        logic [7:0]  tx_cycle;
        logic [15:0] tx_time;
    } rsp_t;

endpackage

>>> sv/sbf_req_if.sv
// request channel: valid, ready and the event fields
// no dependencies
interface sbf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  pkt_command;
    logic [7:0]  pkt_sender;
    logic [7:0]  pkt_cycle;
    logic [15:0] pkt_time;
    logic [15:0] timer_now;

    modport source (
        output valid, mode, pkt_command, pkt_sender, pkt_cycle, pkt_time, timer_now,
        input  ready
    );
    modport sink (
        input  valid, mode, pkt_command, pkt_sender, pkt_cycle, pkt_time, timer_now,
        output ready
    );
endinterface

>>> sv/sbf_rsp_if.sv
// result channel: valid, ready and the result fields
// no dependencies
interface sbf_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  led_level;
    logic        led_enable;
    logic [7:0]  cycle_index;
    logic        load_timer;
    logic [15:0] timer_value;
    logic [2:0]  radio_cmd;
    logic [7:0]  tx_addr;
    logic [7:0]  tx_cycle;
    logic [15:0] tx_time;

    modport source (
        output valid, led_level, led_enable, cycle_index, load_timer, timer_value,
               radio_cmd, tx_addr, tx_cycle, tx_time,
        input  ready
    );
    modport sink (
        input  valid, led_level, led_enable, cycle_index, load_timer, timer_value,
               radio_cmd, tx_addr, tx_cycle, tx_time,
        output ready
    );
endinterface

>>> sv/sbf_cfg.sv
// configuration register file, write only
// depends on sbf_pkg
module sbf_cfg
    import sbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_addr     <= 8'd0;
            cfg_reg.command_code <= 8'd0;
            cfg_reg.subcycles    <= 8'd8;
            cfg_reg.band_low_top <= 8'd32;
            cfg_reg.band_mid_top <= 8'd128;
            cfg_reg.delay_long   <= 16'd20;
            cfg_reg.delay_mid    <= 16'd10;
            cfg_reg.delay_fast   <= 16'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_OWN_ADDR:     cfg_reg.own_addr     <= cfg_data[7:0];
                REG_COMMAND_CODE: cfg_reg.command_code <= cfg_data[7:0];
                REG_SUBCYCLES:    cfg_reg.subcycles    <= cfg_data[7:0];
                REG_BAND_LOW_TOP: cfg_reg.band_low_top <= cfg_data[7:0];
                REG_BAND_MID_TOP: cfg_reg.band_mid_top <= cfg_data[7:0];
                REG_DELAY_LONG:   cfg_reg.delay_long   <= cfg_data;
                REG_DELAY_MID:    cfg_reg.delay_mid    <= cfg_data;
                REG_DELAY_FAST:   cfg_reg.delay_fast   <= cfg_data;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/sbf_core.sv
// event processing: fader, slot sync and transmit fields with their state registers
// depends on sbf_pkg
module sbf_core
    import sbf_pkg::*;
#(
    parameter logic [7:0] LEVEL_MAX = 8'd255
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  req_t req,
    input  cfg_t cfg,
    output rsp_t rsp
);

    logic [7:0]  level_reg,   level_next;
    logic [7:0]  target_reg,  target_next;
    logic        pwm_reg,     pwm_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  sub_reg,     sub_next;

    logic [15:0] elapsed_inc;
    logic [15:0] band_delay;
    logic        step;
    logic [7:0]  sub_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= 8'd0;
            target_reg  <= 8'd0;
            pwm_reg     <= 1'b0;
            elapsed_reg <= 16'd0;
            sub_reg     <= 8'd0;
        end
        else if (advance)
        begin
            level_reg   <= level_next;
            target_reg  <= target_next;
            pwm_reg     <= pwm_next;
            elapsed_reg <= elapsed_next;
            sub_reg     <= sub_next;
        end
    end

    // saturating tick count and band delay select
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign step        = (elapsed_inc >= band_delay);
    assign sub_inc     = sub_reg + 8'd1;

    always_comb
    begin
        priority if (level_reg <= cfg.band_low_top)
            band_delay = cfg.delay_long;
        else if (level_reg <= cfg.band_mid_top)
            band_delay = cfg.delay_mid;
        else
            band_delay = cfg.delay_fast;
    end

    always_comb
    begin
        level_next   = level_reg;
        target_next  = target_reg;
        pwm_next     = pwm_reg;
        elapsed_next = elapsed_reg;
        sub_next     = sub_reg;
        rsp          = '0;
        rsp.radio_cmd = RADIO_NONE;

        unique case (req.mode)
            MODE_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (level_reg != target_reg)
                begin
                    if (target_reg < level_reg)
                    begin
                        if (step)
                        begin
                            level_next   = level_reg - 8'd1;
                            elapsed_next = 16'd0;
                        end
                        if (level_next == 8'd0)
                            pwm_next = 1'b0;
                    end
                    else
                    begin
                        if (level_reg == 8'd0)
                            pwm_next = 1'b1;
                        if (step)
                        begin
                            level_next   = level_reg + 8'd1;
                            elapsed_next = 16'd0;
                        end
                    end
                end
            end
            MODE_PACKET:
            begin
                if (req.pkt_command == cfg.command_code)
                begin
                    target_next = LEVEL_MAX;
                    if (req.pkt_sender < cfg.own_addr)
                    begin
                        sub_next        = req.pkt_cycle;
                        rsp.load_timer  = 1'b1;
                        rsp.timer_value = req.pkt_time;
                    end
                end
            end
            MODE_SUBCYCLE:
            begin
                if (sub_inc >= cfg.subcycles)
                begin
                    sub_next      = 8'd0;
                    target_next   = 8'd0;
                    rsp.radio_cmd = RADIO_RX;
                end
                else
                begin
                    sub_next      = sub_inc;
                    rsp.radio_cmd = RADIO_IDLE;
                end
            end
            MODE_TX_SLOT:
            begin
                rsp.tx_addr   = cfg.own_addr;
                rsp.tx_cycle  = sub_reg;
                rsp.tx_time   = req.timer_now;
                rsp.radio_cmd = (sub_reg == 8'd0) ? RADIO_TX_RX : RADIO_TX_IDLE;
            end
        endcase

        rsp.led_level   = level_next;
        rsp.led_enable  = pwm_next;
        rsp.cycle_index = sub_next;
    end

endmodule

>>> sv/slot_sync_beacon_led_fader.sv
// Beacon slot sync controller with LED fader. Each request (tick, received packet,
// subcycle end or transmit slot) gives exactly one result. A request is held in an
// input register, processed by combinational logic against fader and subcycle state,
// and the result is held in an output register, so one request is taken every cycle
// while the result side keeps up. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while no request is in flight, as the block
// does not enforce it. Depends on sbf_pkg, sbf_req_if, sbf_rsp_if, sbf_cfg, sbf_core.
module slot_sync_beacon_led_fader
    import sbf_pkg::*;
#(
    parameter logic [7:0] LEVEL_MAX = 8'd255
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sbf_req_if.sink               req,
    sbf_rsp_if.source             rsp
);

    cfg_t cfg;
    req_t req_reg;
    logic req_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic advance;

    sbf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbf_core #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .rsp     (rsp_next)
    );

    // move the held request into the result register when that is free
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                req_valid_reg <= req.valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_reg.mode        <= mode_t'(req.mode);
            req_reg.pkt_command <= req.pkt_command;
            req_reg.pkt_sender  <= req.pkt_sender;
            req_reg.pkt_cycle   <= req.pkt_cycle;
            req_reg.pkt_time    <= req.pkt_time;
            req_reg.timer_now   <= req.timer_now;
        end
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.led_level   = rsp_reg.led_level;
    assign rsp.led_enable  = rsp_reg.led_enable;
    assign rsp.cycle_index = rsp_reg.cycle_index;
    assign rsp.load_timer  = rsp_reg.load_timer;
    assign rsp.timer_value = rsp_reg.timer_value;
    assign rsp.radio_cmd   = rsp_reg.radio_cmd;
    assign rsp.tx_addr     = rsp_reg.tx_addr;
    assign rsp.tx_cycle    = rsp_reg.tx_cycle;
    assign rsp.tx_time     = rsp_reg.tx_time;

endmodule
